@@ rtl/smf_pkg.sv @@
package smf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_W = 4;
   localparam int MAX_RADIUS_DEFAULT = 8;
   localparam int RADIUS_RESET = 1;

   localparam logic CH_LEFT = 1'b0;
   localparam logic CH_RIGHT = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type sample_in;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      sample_type median_out;
      logic       channel;
      logic       last_out;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic channel;
      logic last;
   } job_ctrl_type;

   typedef enum logic {
      SEQ_RUN,
      SEQ_FLUSH
   } seq_state_type;

endpackage

@@ rtl/stereo_median_filter.sv @@
// pipeline: a result moves in order through the input register, compare, rank and output
// register stages, starting at the edge that accepts its request or takes its flush step
// throughput: one request per cycle unless rsp_ready stalls the pipeline; an end_of_stream
// request is followed by up to 2*radius flush steps, one result each, with req_ready low
// reset: synchronous active high, clears both windows, pending counts, channel to left,
// radius to 1 and the pipeline valid flags; csr writes are always taken
module stereo_median_filter #(
   parameter int MAX_RADIUS = smf_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  smf_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output smf_pkg::rsp_type           rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [smf_pkg::CSR_W-1:0]  csr_data
);

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int RW = $clog2(MAX_RADIUS + 1);

   smf_pkg::job_ctrl_type job_ctrl;
   smf_pkg::sample_type [DEPTH-1:0] job_win;
   logic [RW-1:0] job_radius;
   logic job_ready;

   smf_seq #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .job_ctrl(job_ctrl),
      .job_win(job_win),
      .job_radius(job_radius),
      .job_ready(job_ready)
   );

   smf_median #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_median (
      .clock(clock),
      .reset(reset),
      .job_ctrl(job_ctrl),
      .job_win(job_win),
      .job_radius(job_radius),
      .job_ready(job_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

@@ rtl/smf_seq.sv @@
module smf_seq #(
   parameter int MAX_RADIUS = smf_pkg::MAX_RADIUS_DEFAULT,
   localparam int DEPTH = 2 * MAX_RADIUS + 1,
   localparam int RW = $clog2(MAX_RADIUS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  smf_pkg::req_type                  req_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smf_pkg::CSR_W-1:0]         csr_data,
   output smf_pkg::job_ctrl_type             job_ctrl,
   output smf_pkg::sample_type [DEPTH-1:0]   job_win,
   output logic [RW-1:0]                     job_radius,
   input  logic                              job_ready
);

   smf_pkg::seq_state_type state_ff, state_in;
   smf_pkg::sample_type [DEPTH-1:0] left_win_ff, left_win_in;
   smf_pkg::sample_type [DEPTH-1:0] right_win_ff, right_win_in;
   logic [RW-1:0] pend_left_ff, pend_left_in;
   logic [RW-1:0] pend_right_ff, pend_right_in;
   logic [RW-1:0] radius_ff, radius_in;
   logic toggle_ff, toggle_in;
   logic fch_ff, fch_in;

   logic sel_ch;
   logic [RW-1:0] pend_sel, pend_oth;
   smf_pkg::sample_type [DEPTH-1:0] win_sel, win_shift;
   smf_pkg::sample_type shift_val;
   logic flush_last;
   logic [RW-1:0] eff;

   assign csr_ready = 1'b1;
   assign job_radius = radius_ff;
   assign job_win = win_shift;

   always_comb begin
      state_in = state_ff;
      left_win_in = left_win_ff;
      right_win_in = right_win_ff;
      pend_left_in = pend_left_ff;
      pend_right_in = pend_right_ff;
      radius_in = radius_ff;
      toggle_in = toggle_ff;
      fch_in = fch_ff;
      req_ready = 1'b0;
      job_ctrl = '0;

      case (state_ff)
         smf_pkg::SEQ_RUN: sel_ch = toggle_ff;
         smf_pkg::SEQ_FLUSH: begin
            if (fch_ff == smf_pkg::CH_RIGHT) begin
               sel_ch = (pend_right_ff != '0) ? smf_pkg::CH_RIGHT : smf_pkg::CH_LEFT;
            end else begin
               sel_ch = (pend_left_ff != '0) ? smf_pkg::CH_LEFT : smf_pkg::CH_RIGHT;
            end
         end
         default: sel_ch = toggle_ff;
      endcase

      pend_sel = (sel_ch == smf_pkg::CH_RIGHT) ? pend_right_ff : pend_left_ff;
      pend_oth = (sel_ch == smf_pkg::CH_RIGHT) ? pend_left_ff : pend_right_ff;
      win_sel = (sel_ch == smf_pkg::CH_RIGHT) ? right_win_ff : left_win_ff;
      shift_val = (state_ff == smf_pkg::SEQ_RUN) ? req_payload.sample_in : '0;
      win_shift = {win_sel[DEPTH-2:0], shift_val};
      flush_last = (pend_sel == RW'(1)) && (pend_oth == '0);
      job_ctrl.channel = sel_ch;

      case (state_ff)
         smf_pkg::SEQ_RUN: begin
            req_ready = job_ready;
            job_ctrl.valid = req_valid && (pend_sel == radius_ff);
            if (req_valid && job_ready) begin
               if (sel_ch == smf_pkg::CH_RIGHT) begin
                  right_win_in = win_shift;
                  if (pend_sel < radius_ff) pend_right_in = pend_sel + RW'(1);
               end else begin
                  left_win_in = win_shift;
                  if (pend_sel < radius_ff) pend_left_in = pend_sel + RW'(1);
               end
               toggle_in = ~toggle_ff;
               if (req_payload.end_of_stream) begin
                  state_in = smf_pkg::SEQ_FLUSH;
                  fch_in = smf_pkg::CH_LEFT;
               end
            end
         end
         smf_pkg::SEQ_FLUSH: begin
            job_ctrl.valid = 1'b1;
            job_ctrl.last = flush_last;
            if (job_ready) begin
               if (sel_ch == smf_pkg::CH_RIGHT) begin
                  right_win_in = win_shift;
                  pend_right_in = pend_sel - RW'(1);
               end else begin
                  left_win_in = win_shift;
                  pend_left_in = pend_sel - RW'(1);
               end
               fch_in = ~sel_ch;
               if (flush_last) begin
                  state_in = smf_pkg::SEQ_RUN;
                  left_win_in = '0;
                  right_win_in = '0;
                  pend_left_in = '0;
                  pend_right_in = '0;
                  toggle_in = smf_pkg::CH_LEFT;
                  fch_in = smf_pkg::CH_LEFT;
               end
            end
         end
         default: begin
            state_in = smf_pkg::SEQ_RUN;
         end
      endcase

      if (csr_data == '0) begin
         eff = RW'(1);
      end else if (int'(csr_data) > MAX_RADIUS) begin
         eff = RW'(MAX_RADIUS);
      end else begin
         eff = RW'(csr_data);
      end

      if (csr_valid) begin
         radius_in = eff;
         if (pend_left_in > eff) pend_left_in = eff;
         if (pend_right_in > eff) pend_right_in = eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smf_pkg::SEQ_RUN;
         left_win_ff <= '0;
         right_win_ff <= '0;
         pend_left_ff <= '0;
         pend_right_ff <= '0;
         radius_ff <= RW'(smf_pkg::RADIUS_RESET);
         toggle_ff <= smf_pkg::CH_LEFT;
         fch_ff <= smf_pkg::CH_LEFT;
      end else begin
         state_ff <= state_in;
         left_win_ff <= left_win_in;
         right_win_ff <= right_win_in;
         pend_left_ff <= pend_left_in;
         pend_right_ff <= pend_right_in;
         radius_ff <= radius_in;
         toggle_ff <= toggle_in;
         fch_ff <= fch_in;
      end
   end

endmodule

@@ rtl/smf_median.sv @@
module smf_median #(
   parameter int MAX_RADIUS = smf_pkg::MAX_RADIUS_DEFAULT,
   localparam int DEPTH = 2 * MAX_RADIUS + 1,
   localparam int RW = $clog2(MAX_RADIUS + 1),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  smf_pkg::job_ctrl_type             job_ctrl,
   input  smf_pkg::sample_type [DEPTH-1:0]   job_win,
   input  logic [RW-1:0]                     job_radius,
   output logic                              job_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output smf_pkg::rsp_type                  rsp_payload
);

   logic en1, en2, en3, en_out;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;

   smf_pkg::sample_type [DEPTH-1:0] s1_win_ff, s2_win_ff, s3_win_ff;
   logic [RW-1:0] s1_r_ff, s2_r_ff;
   logic s1_ch_ff, s2_ch_ff, s3_ch_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff;

   logic [DEPTH-1:0][DEPTH-1:0] s2_lt_ff, s2_lt_in;
   logic [DEPTH-1:0] s2_act_ff, s2_act_in;
   logic [DEPTH-1:0] s3_hit_ff, s3_hit_in;
   smf_pkg::sample_type med_in;
   smf_pkg::rsp_type rsp_ff;

   assign en_out = !rsp_valid_ff || rsp_ready;
   assign en3 = !s3_valid_ff || en_out;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign job_ready = en1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // pairwise compares, lt[i][j] means w[j] < w[i]
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         s2_act_in[i] = (i <= 2 * int'(s1_r_ff));
         for (int j = 0; j < DEPTH; j++) begin
            s2_lt_in[i][j] = ($signed(s1_win_ff[j]) < $signed(s1_win_ff[i]));
         end
      end
   end

   // rank test per element
   always_comb begin
      logic [CW-1:0] lt_cnt;
      logic [CW-1:0] le_cnt;
      logic [DEPTH-1:0] le_row;
      for (int i = 0; i < DEPTH; i++) begin
         for (int j = 0; j < DEPTH; j++) begin
            le_row[j] = !s2_lt_ff[j][i];
         end
         lt_cnt = CW'($countones(s2_act_ff & s2_lt_ff[i]));
         le_cnt = CW'($countones(s2_act_ff & le_row));
         s3_hit_in[i] = s2_act_ff[i] && (lt_cnt <= CW'(s2_r_ff)) && (CW'(s2_r_ff) < le_cnt);
      end
   end

   // all hits carry the same value
   always_comb begin
      med_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (s3_hit_ff[i]) med_in = med_in | s3_win_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= job_ctrl.valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en_out) rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_win_ff <= job_win;
         s1_r_ff <= job_radius;
         s1_ch_ff <= job_ctrl.channel;
         s1_last_ff <= job_ctrl.last;
      end
      if (en2) begin
         s2_win_ff <= s1_win_ff;
         s2_r_ff <= s1_r_ff;
         s2_lt_ff <= s2_lt_in;
         s2_act_ff <= s2_act_in;
         s2_ch_ff <= s1_ch_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (en3) begin
         s3_win_ff <= s2_win_ff;
         s3_hit_ff <= s3_hit_in;
         s3_ch_ff <= s2_ch_ff;
         s3_last_ff <= s2_last_ff;
      end
      if (en_out) begin
         rsp_ff.median_out <= med_in;
         rsp_ff.channel <= s3_ch_ff;
         rsp_ff.last_out <= s3_last_ff;
      end
   end

endmodule
